/* src/gs_pkg.sv */
// Package for the Gauss-Seidel solver core: payload structs, state enum, constants.
// Used by all modules under src.
package gs_pkg;

    localparam int MAX_ORDER_DEF     = 16;
    localparam int COEF_WIDTH_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 16;

    localparam logic [1:0] ST_CONVERGED = 2'd0;
    localparam logic [1:0] ST_NOT_DOM   = 2'd1;
    localparam logic [1:0] ST_LIMIT     = 2'd2;

    localparam logic [1:0] REG_ORDER = 2'd0;
    localparam logic [1:0] REG_TOL   = 2'd1;
    localparam logic [1:0] REG_LIMIT = 2'd2;

    localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] ACC_MIN = -64'sh7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [15:0] coefficient;
        logic               final_element;
    } t_in;

    typedef struct packed {
        logic [3:0]         unknown_index;
        logic signed [47:0] solution_value;
        logic [1:0]         status;
        logic [15:0]        sweeps_done;
        logic               last_result;
    } t_out;

    typedef enum logic [3:0] {
        S_LOAD, S_DOM_RD, S_DOM_ACC, S_DOM_CHK, S_ERR,
        S_ROW_B, S_MAC_RD, S_MAC_MUL, S_MAC_ACC, S_DIV, S_DIV_RUN, S_SWEEP_END,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic               start;
        logic signed [63:0] num;
        logic signed [16:0] den;
    } t_div_req;

endpackage

/* src/gs_div.sv */
// Iterative signed divider: 64-bit dividend by 17-bit divisor, one quotient bit a cycle.
// Truncates toward zero and saturates to 48 bits; uses gs_pkg.
module gs_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gs_pkg::t_div_req i_req,
    output logic             o_busy,
    output logic signed [47:0] o_quot
);
    import gs_pkg::*;

    logic        r_busy, n_busy;
    logic [6:0]  r_cnt, n_cnt;
    logic [63:0] r_q, n_q;
    logic [16:0] r_rem, n_rem;
    logic [16:0] r_d;
    logic        r_neg;
    logic [17:0] w_trial;
    logic [63:0] w_mag;
    logic signed [64:0] w_sq;

    assign w_trial = {r_rem, r_q[63]} - {1'b0, r_d};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 7'd64;
            n_q    = i_req.num[63] ? 64'(-i_req.num) : 64'(i_req.num);
            n_rem  = '0;
        end else if (r_busy) begin
            if (!w_trial[17]) begin
                n_rem = w_trial[16:0];
                n_q   = {r_q[62:0], 1'b1};
            end else begin
                n_rem = {r_rem[15:0], r_q[63]};
                n_q   = {r_q[62:0], 1'b0};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        if (i_req.start) begin
            r_d   <= i_req.den[16] ? 17'(-i_req.den) : 17'(i_req.den);
            r_neg <= i_req.num[63] ^ i_req.den[16];
        end
    end

    assign o_busy = r_busy;
    assign w_mag  = r_q;
    assign w_sq   = r_neg ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});

    always_comb begin
        if (w_sq > 65'sh7FFF_FFFF_FFFF)
            o_quot = 48'sh7FFF_FFFF_FFFF;
        else if (w_sq < -65'sh8000_0000_0000)
            o_quot = 48'sh8000_0000_0000;
        else
            o_quot = w_sq[47:0];
    end
endmodule

/* src/gauss_seidel_linear_solver_core.sv */
// Top level of the Gauss-Seidel solver: matrix memory, sequencer, shared
// multiply-accumulate and iterative divider. Depends on gs_pkg and gs_div.
//
//  channel | signals                          | dir
//  in      | i_in_valid o_in_ready i_in       | load one coefficient per beat
//  cfg     | i_cfg_valid o_cfg_ready i_cfg_*  | register writes
//  out     | o_out_valid i_out_ready o_out    | one result per beat
//
// Loading accepts one coefficient per cycle. After the final beat the dominance
// check reads each element of a row in turn, and each sweep reads, multiplies
// and accumulates each element in turn, then runs the bit-serial divide once
// per unknown; the shared memory read port and the divider set the pace. Input
// is not ready during the solve and while results are emitted; results stall on i_out_ready.
module gauss_seidel_linear_solver_core #(
    parameter int MAX_ORDER     = gs_pkg::MAX_ORDER_DEF,
    parameter int COEF_WIDTH    = gs_pkg::COEF_WIDTH_DEF,
    parameter int FRACTION_BITS = gs_pkg::FRACTION_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  gs_pkg::t_in  i_in,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output gs_pkg::t_out o_out
);
    import gs_pkg::*;

    localparam int DEPTH = MAX_ORDER * (MAX_ORDER + 1);
    localparam int AW    = $clog2(DEPTH + 1);
    localparam int IW    = $clog2(MAX_ORDER);
    localparam int NW    = $clog2(MAX_ORDER + 1);

    logic signed [15:0] mem [DEPTH];
    logic signed [15:0] r_rd;

    logic [4:0]  r_order;
    logic [15:0] r_tol, r_limit;
    logic [AW-1:0] r_lpos, n_lpos;
    t_state r_st, n_st;
    logic [NW-1:0] r_n;
    logic [IW-1:0] r_i, n_i;
    logic [IW:0]   r_jc, n_jc;
    logic [AW-1:0] r_rowbase, n_rowbase;
    logic [AW-1:0] w_addr;
    logic [15:0] r_sweeps, n_sweeps;
    logic        r_ok, n_ok;
    logic [1:0]  r_status, n_status;
    logic signed [47:0] x [MAX_ORDER];
    logic signed [63:0] r_acc, n_acc;
    logic signed [63:0] r_prod;
    logic signed [16:0] r_diag, n_diag;
    logic [31:0] r_dsum, n_dsum;
    logic        w_wr_x;
    logic signed [47:0] w_q;
    t_div_req    w_req;
    logic        w_dbusy;
    logic [16:0] w_absrd;
    logic signed [48:0] w_delta;
    logic [48:0] w_adelta;

    // effective order and limit
    logic [NW-1:0] w_n;
    always_comb begin
        if (r_order == 5'd0) w_n = NW'(1);
        else if (32'(r_order) > MAX_ORDER) w_n = NW'(MAX_ORDER);
        else w_n = NW'(r_order);
    end
    logic [15:0] w_lim;
    assign w_lim = (r_limit == 16'd0) ? 16'd1 : r_limit;

    assign w_addr    = r_rowbase + AW'(r_jc);
    assign w_absrd   = r_rd[15] ? 17'(-$signed({r_rd[15], r_rd})) : {1'b0, r_rd};
    assign o_cfg_ready = (r_st == S_LOAD);
    assign o_in_ready  = (r_st == S_LOAD);

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= 5'd2;
            r_tol   <= 16'd66;
            r_limit <= 16'd1000;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_ORDER: r_order <= i_cfg_data[4:0];
                REG_TOL:   r_tol   <= i_cfg_data;
                REG_LIMIT: r_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // memory: write on load, read at sequencer address
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready && r_lpos < AW'(DEPTH))
            mem[r_lpos[AW-1:0]] <= 16'($signed(i_in.coefficient[COEF_WIDTH-1:0]));
        r_rd <= mem[w_addr];
    end

    assign w_delta  = {x[r_i][47], x[r_i]} - {w_q[47], w_q};
    assign w_adelta = w_delta[48] ? 49'(-w_delta) : 49'(w_delta);

    always_comb begin
        n_st = r_st; n_i = r_i; n_jc = r_jc; n_lpos = r_lpos;
        n_sweeps = r_sweeps; n_ok = r_ok; n_status = r_status; n_acc = r_acc;
        n_diag = r_diag; n_dsum = r_dsum; w_wr_x = 1'b0;
        w_req = '{start: 1'b0, num: r_acc, den: r_diag};
        o_out_valid = 1'b0;
        o_out = '0;
        case (r_st)
            S_LOAD: begin
                if (i_in_valid) begin
                    if (r_lpos < AW'(DEPTH)) n_lpos = r_lpos + AW'(1);
                    if (i_in.final_element) begin
                        n_lpos = '0; n_i = '0; n_jc = '0; n_dsum = '0;
                        n_st = S_DOM_RD;
                    end
                end
            end
            S_DOM_RD: n_st = S_DOM_ACC;  // read in flight
            S_DOM_ACC: begin
                if (IW'(r_jc) == r_i) n_diag = $signed(w_absrd);
                else n_dsum = r_dsum + 32'(w_absrd);
                if (r_jc == (IW+1)'(r_n) - 1'b1) n_st = S_DOM_CHK;
                else begin n_jc = r_jc + 1'b1; n_st = S_DOM_RD; end
            end
            S_DOM_CHK: begin
                n_jc = '0; n_dsum = '0;
                if (32'(r_diag) <= r_dsum) n_st = S_ERR;
                else if (NW'(r_i) == r_n - 1'b1) begin
                    n_i = '0; n_sweeps = '0; n_ok = 1'b1;
                    n_jc = (IW+1)'(r_n); n_st = S_ROW_B;
                end else begin n_i = r_i + 1'b1; n_st = S_DOM_RD; end
            end
            S_ERR: begin
                o_out_valid = 1'b1;
                o_out = '{unknown_index: '0, solution_value: '0, status: ST_NOT_DOM,
                          sweeps_done: '0, last_result: 1'b1};
                if (i_out_ready) n_st = S_LOAD;
            end
            S_ROW_B: begin  // b read is in flight at jc = n
                n_st = S_MAC_RD;
            end
            S_MAC_RD: begin
                if (r_jc == (IW+1)'(r_n)) begin
                    // load b, then issue the read of the first coefficient
                    n_acc = 64'(r_rd) <<< FRACTION_BITS;
                    n_jc = '0;
                    n_st = S_MAC_RD;
                end else begin
                    n_st = S_MAC_MUL;
                end
            end
            S_MAC_MUL: n_st = S_MAC_ACC;
            S_MAC_ACC: begin
                if (IW'(r_jc) == r_i && r_jc != (IW+1)'(r_n)) n_diag = r_rd;
                else if (r_jc != (IW+1)'(r_n) || 1'b0) begin
                    // saturating subtract of product
                    if (r_prod < 0 && r_acc > ACC_MAX + r_prod) n_acc = ACC_MAX;
                    else if (r_prod > 0 && r_acc < ACC_MIN + r_prod) n_acc = ACC_MIN;
                    else n_acc = r_acc - r_prod;
                end
                if (r_jc == (IW+1)'(r_n) - 1'b1) n_st = S_DIV;
                else begin n_jc = r_jc + 1'b1; n_st = S_MAC_RD; end
            end
            S_DIV: begin
                w_req.start = 1'b1;
                n_st = S_DIV_RUN;
            end
            S_DIV_RUN: begin
                if (!w_dbusy) begin
                    w_wr_x = 1'b1;
                    if (w_adelta > 49'(r_tol)) n_ok = 1'b0;
                    n_jc = (IW+1)'(r_n);
                    if (NW'(r_i) == r_n - 1'b1) n_st = S_SWEEP_END;
                    else begin n_i = r_i + 1'b1; n_st = S_ROW_B; end
                end
            end
            S_SWEEP_END: begin
                n_i = '0; n_jc = (IW+1)'(r_n);
                if (r_ok) begin n_status = ST_CONVERGED; n_st = S_EMIT; end
                else if (r_sweeps >= w_lim) begin n_status = ST_LIMIT; n_st = S_EMIT; end
                else begin n_ok = 1'b1; n_st = S_ROW_B; end
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                o_out = '{unknown_index: 4'(r_i), solution_value: x[r_i],
                          status: r_status, sweeps_done: r_sweeps,
                          last_result: (NW'(r_i) == r_n - 1'b1)};
                if (i_out_ready) begin
                    if (NW'(r_i) == r_n - 1'b1) n_st = S_LOAD;
                    else n_i = r_i + 1'b1;
                end
            end
            default: n_st = S_LOAD;
        endcase
        n_rowbase = AW'(32'(n_i) * (32'(r_n) + 1));
        if (r_st == S_SWEEP_END && !r_ok && !(r_sweeps >= w_lim)) n_sweeps = r_sweeps;
    end

    // sweep counter bumps when the last unknown of a sweep is written
    logic w_sweep_inc;
    assign w_sweep_inc = w_wr_x && (NW'(r_i) == r_n - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_LOAD; r_lpos <= '0; r_i <= '0; r_jc <= '0; r_n <= NW'(1);
            r_sweeps <= '0; r_ok <= 1'b0; r_status <= ST_CONVERGED; r_rowbase <= '0;
        end else begin
            r_st <= n_st; r_lpos <= n_lpos; r_i <= n_i; r_jc <= n_jc;
            r_sweeps <= w_sweep_inc ? r_sweeps + 16'd1 : n_sweeps;
            r_ok <= n_ok; r_status <= n_status; r_rowbase <= n_rowbase;
            if (r_st == S_LOAD) r_n <= w_n;
        end
        r_acc <= n_acc; r_diag <= n_diag; r_dsum <= n_dsum;
    end

    // shared multiplier: coefficient times unknown, saturated to 63 bits
    logic signed [63:0] w_p;
    always_comb w_p = 64'(r_rd) * 64'(x[IW'(r_jc)]);
    always_ff @(posedge i_clk) begin
        if (IW'(r_jc) == r_i || r_jc == (IW+1)'(r_n)) r_prod <= '0;
        else r_prod <= (w_p == 64'sh8000_0000_0000_0000) ? ACC_MIN : w_p;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_ORDER; k++) begin
            if (!i_rst_n || (r_st == S_DOM_CHK && n_st == S_ROW_B)) x[k] <= '0;
            else if (w_wr_x && IW'(k) == r_i) x[k] <= w_q;
        end
    end

    gs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_busy  (w_dbusy),
        .o_quot  (w_q)
    );
endmodule
